[rtl/core/rsnh_pkg.sv]
package rsnh_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF   = 32;

  // Configuration register indexes.
  localparam logic CFG_EDGE_COUNT = 1'b0;
  localparam logic CFG_VERT_THR   = 1'b1;

  // Item modes.
  localparam logic MODE_SEGMENT = 1'b0;
  localparam logic MODE_RAY     = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [5:0]         edge_slot;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic               hit_found;
    logic               near_vertical;
  } out_word_t;

  // Effective coordinate width: never more than 32 bits.
  function automatic int unsigned coord_width(int unsigned cb);
    return (cb < 32) ? cb : 32;
  endfunction

  // Width of the magnitudes the datapath multiplies, a multiple of four
  // with at least two spare bits above the widest cross product difference.
  function automatic int unsigned mag_width(int unsigned cb);
    return (2 * coord_width(cb) + 7) & ~32'd3;
  endfunction

endpackage

[rtl/core/ray_segment_nearest_hit_core.sv]
// Nearest hit of a 2D ray against a table of wall segments, in signed Q24.8.
// A word with mode 0 writes one segment into the table and returns nothing;
// the block is ready again in the next cycle. A word with mode 1 casts a ray
// and returns exactly one result word, shown for a single cycle with
// res_valid_o high; the receiver cannot stall, so it must take the word then.
// A ray whose absolute x direction is below vertical_threshold is answered in
// the cycle right after the one that takes it. Otherwise the block walks
// edge_count segments (capped at MAX_SEGMENTS). Every segment costs six
// products on one shared radix-16 multiplier (operands MAG bits wide, 68 at
// 32-bit coordinates), plus a table read, operand setup and evaluation; a
// segment that is hit while an earlier hit is held costs two more products
// and a compare step. The winning hit then takes two products and two
// restoring divisions of COORD+1 bits. busy stays high while a ray is in
// flight. Configuration writes are always taken and must be issued only
// while the block is idle.
module ray_segment_nearest_hit_core #(
  parameter int unsigned MAX_SEGMENTS = rsnh_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = rsnh_pkg::COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rsnh_pkg::in_word_t  cmd_i,
  output logic                res_valid_o,
  output rsnh_pkg::out_word_t res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import rsnh_pkg::*;

  localparam int unsigned CW   = coord_width(COORD_BITS);
  localparam int unsigned MB   = mag_width(COORD_BITS);
  localparam int unsigned AW   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNTW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_LD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_MWT  = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DWT  = 4'd8;

  // Products the shared multiplier forms, in the order they are issued.
  localparam logic [3:0] OP_BX_AY = 4'd0;
  localparam logic [3:0] OP_BY_AX = 4'd1;
  localparam logic [3:0] OP_AX_DY = 4'd2;
  localparam logic [3:0] OP_AY_DX = 4'd3;
  localparam logic [3:0] OP_BX_DY = 4'd4;
  localparam logic [3:0] OP_BY_DX = 4'd5;
  localparam logic [3:0] OP_CAND  = 4'd6;
  localparam logic [3:0] OP_BEST  = 4'd7;
  localparam logic [3:0] OP_HIT_X = 4'd8;
  localparam logic [3:0] OP_HIT_Y = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [3:0]  op_q, op_d;
  logic [CNTW-1:0] k_q, k_d;
  logic        found_q, found_d;

  logic [6:0]  edge_count_q;
  logic [7:0]  vert_thr_q;

  logic [4*CW-1:0] seg_mem [MAX_SEGMENTS];
  logic [4*CW-1:0] rd_q;

  logic signed [CW-1:0] sx_q, sy_q, ax_q, ay_q;
  logic signed [CW:0]   bx_q, by_q, dx_q, dy_q;
  logic signed [MB-1:0] prod_q [6];
  logic signed [MB-1:0] den_q, num1_q, best_n_q, best_d_q;
  logic [2*MB-1:0]      cand_prod_q;
  logic                 mul_neg_q;
  logic signed [31:0]   hx_q;

  out_word_t out_q;
  logic      out_valid_q;

  logic accept;
  assign busy   = state_q != S_IDLE;
  assign accept = start && !busy;

  // Configuration port: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= 7'd0;
      vert_thr_q   <= 8'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EDGE_COUNT: edge_count_q <= cfg_data_i[6:0];
        CFG_VERT_THR:   vert_thr_q   <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Segment table: one write port from segment words, one registered read
  // port addressed by the walk counter.
  logic slot_ok;
  logic [AW-1:0] waddr;
  assign slot_ok = 32'(cmd_i.edge_slot) < MAX_SEGMENTS;
  assign waddr   = AW'(32'(cmd_i.edge_slot));

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.mode == MODE_SEGMENT && slot_ok) begin
      seg_mem[waddr] <= {cmd_i.seg_start_x[CW-1:0], cmd_i.seg_start_y[CW-1:0],
                         cmd_i.seg_end_x[CW-1:0], cmd_i.seg_end_y[CW-1:0]};
    end
    rd_q <= seg_mem[k_q[AW-1:0]];
  end

  // Number of entries walked.
  logic [CNTW-1:0] lim;
  assign lim = (32'(edge_count_q) < MAX_SEGMENTS) ? CNTW'(edge_count_q)
                                                 : CNTW'(MAX_SEGMENTS);

  // Near vertical test on the incoming direction.
  logic signed [CW:0] ax_ext;
  logic [CW:0]        adx;
  logic               near_vert;
  assign ax_ext    = (CW+1)'(signed'(cmd_i.dir_x[CW-1:0]));
  assign adx       = ax_ext[CW] ? -ax_ext : ax_ext;
  assign near_vert = adx < (CW+1)'(vert_thr_q);

  // Table entry fields.
  logic signed [CW:0] p1x, p1y, p2x, p2y;
  assign p1x = (CW+1)'(signed'(rd_q[4*CW-1:3*CW]));
  assign p1y = (CW+1)'(signed'(rd_q[3*CW-1:2*CW]));
  assign p2x = (CW+1)'(signed'(rd_q[2*CW-1:CW]));
  assign p2y = (CW+1)'(signed'(rd_q[CW-1:0]));

  // Operand selection for the shared multiplier.
  logic signed [MB-1:0] opa, opb;
  logic [MB-1:0]        a_mag, b_mag;
  logic                 mul_start;
  logic                 mul_done;
  logic [2*MB-1:0]      mul_prod;

  always_comb begin
    unique case (op_q)
      OP_BX_AY: begin opa = MB'(bx_q);     opb = MB'(ay_q);     end
      OP_BY_AX: begin opa = MB'(by_q);     opb = MB'(ax_q);     end
      OP_AX_DY: begin opa = MB'(ax_q);     opb = MB'(dy_q);     end
      OP_AY_DX: begin opa = MB'(ay_q);     opb = MB'(dx_q);     end
      OP_BX_DY: begin opa = MB'(bx_q);     opb = MB'(dy_q);     end
      OP_BY_DX: begin opa = MB'(by_q);     opb = MB'(dx_q);     end
      OP_CAND:  begin opa = num1_q;        opb = best_d_q;      end
      OP_BEST:  begin opa = best_n_q;      opb = den_q;         end
      OP_HIT_X: begin opa = best_n_q;      opb = MB'(ax_q);     end
      OP_HIT_Y: begin opa = best_n_q;      opb = MB'(ay_q);     end
      default:  begin opa = '0;            opb = '0;            end
    endcase
  end

  assign a_mag     = opa[MB-1] ? MB'(-opa) : MB'(opa);
  assign b_mag     = opb[MB-1] ? MB'(-opb) : MB'(opb);
  assign mul_start = state_q == S_MUL;

  rsnh_mul #(
    .COORD_BITS(COORD_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (a_mag),
    .b_i    (b_mag),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Signed low part of a cross product; the true value always fits.
  logic signed [MB-1:0] prod_lo;
  assign prod_lo = mul_neg_q ? -signed'(mul_prod[MB-1:0]) : signed'(mul_prod[MB-1:0]);

  // Divider for the hit offset, always by the winning denominator.
  logic            div_start, div_done;
  logic [CW+1:0]   quot;
  logic signed [31:0] off;
  logic signed [31:0] hit_val;
  logic signed [31:0] src_val;
  assign div_start = state_q == S_DIV;

  rsnh_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mul_prod),
    .divisor_i (best_d_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign off     = mul_neg_q ? -signed'(32'(quot)) : signed'(32'(quot));
  assign src_val = (op_q == OP_HIT_X) ? 32'(sx_q) : 32'(sy_q);
  assign hit_val = src_val + off;

  // Evaluation of one segment: the sign of the denominator is folded into
  // both numerators so that the tests read as plain compares.
  logic signed [MB-1:0] den_w, num1_w, num2_w, den_n, num1_n, num2_n;
  logic                 cand;
  always_comb begin
    den_w  = prod_q[0] - prod_q[1];
    num2_w = prod_q[2] - prod_q[3];
    num1_w = prod_q[4] - prod_q[5];
    if (den_w < 0) begin
      den_n  = -den_w;
      num1_n = -num1_w;
      num2_n = -num2_w;
    end else begin
      den_n  = den_w;
      num1_n = num1_w;
      num2_n = num2_w;
    end
    cand = (den_w != 0) && (num2_n >= 0) && (num2_n <= den_n) && (num1_n > 0);
  end

  // Sequencer.
  logic out_fire;
  logic load_ray, load_seg, store_prod, take_cand, take_best, store_cand;
  logic store_hx;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    k_d        = k_q;
    found_d    = found_q;
    out_fire   = 1'b0;
    load_ray   = 1'b0;
    load_seg   = 1'b0;
    store_prod = 1'b0;
    take_cand  = 1'b0;
    take_best  = 1'b0;
    store_cand = 1'b0;
    store_hx   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_i.mode == MODE_RAY) begin
          load_ray = 1'b1;
          found_d  = 1'b0;
          k_d      = '0;
          if (near_vert) begin
            out_fire = 1'b1;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (k_q >= lim) begin
          if (found_q) begin
            op_d    = OP_HIT_X;
            state_d = S_MUL;
          end else begin
            out_fire = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_LD;
        end
      end
      S_LD: begin
        load_seg = 1'b1;
        op_d     = OP_BX_AY;
        state_d  = S_MUL;
      end
      S_MUL: begin
        state_d = S_MWT;
      end
      S_MWT: begin
        if (mul_done) begin
          priority if (op_q <= OP_BY_DX) begin
            store_prod = 1'b1;
            if (op_q == OP_BY_DX) begin
              state_d = S_EVAL;
            end else begin
              op_d    = op_q + 4'd1;
              state_d = S_MUL;
            end
          end else if (op_q == OP_CAND) begin
            store_cand = 1'b1;
            op_d       = OP_BEST;
            state_d    = S_MUL;
          end else if (op_q == OP_BEST) begin
            state_d = S_CMP;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_EVAL: begin
        if (cand && found_q) begin
          op_d    = OP_CAND;
          state_d = S_MUL;
        end else begin
          take_cand = cand;
          found_d   = found_q || cand;
          k_d       = k_q + 1'b1;
          state_d   = S_RD;
        end
      end
      S_CMP: begin
        // Strictly nearer only: on a tie the earlier entry stays.
        take_best = cand_prod_q < mul_prod;
        k_d       = k_q + 1'b1;
        state_d   = S_RD;
      end
      S_DIV: begin
        state_d = S_DWT;
      end
      S_DWT: begin
        if (div_done) begin
          if (op_q == OP_HIT_X) begin
            store_hx = 1'b1;
            op_d     = OP_HIT_Y;
            state_d  = S_MUL;
          end else begin
            out_fire = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_BX_AY;
      k_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      found_q     <= found_d;
      out_valid_q <= out_fire;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (load_ray) begin
      sx_q <= cmd_i.origin_x[CW-1:0];
      sy_q <= cmd_i.origin_y[CW-1:0];
      ax_q <= cmd_i.dir_x[CW-1:0];
      ay_q <= cmd_i.dir_y[CW-1:0];
    end
    if (load_seg) begin
      bx_q <= p1x - p2x;
      by_q <= p1y - p2y;
      dx_q <= p2x - (CW+1)'(sx_q);
      dy_q <= p2y - (CW+1)'(sy_q);
    end
    if (mul_start) begin
      mul_neg_q <= opa[MB-1] ^ opb[MB-1];
    end
    if (store_prod) begin
      prod_q[op_q[2:0]] <= prod_lo;
    end
    if (state_q == S_EVAL) begin
      den_q  <= den_n;
      num1_q <= num1_n;
    end
    if (take_cand) begin
      best_n_q <= num1_n;
      best_d_q <= den_n;
    end
    if (take_best) begin
      best_n_q <= num1_q;
      best_d_q <= den_q;
    end
    if (store_cand) begin
      cand_prod_q <= mul_prod;
    end
    if (store_hx) begin
      hx_q <= hit_val;
    end
    if (out_fire) begin
      if (state_q == S_DWT) begin
        out_q.hit_x         <= hx_q;
        out_q.hit_y         <= hit_val;
        out_q.hit_found     <= 1'b1;
        out_q.near_vertical <= 1'b0;
      end else if (state_q == S_IDLE) begin
        out_q.hit_x         <= 32'(signed'(cmd_i.origin_x[CW-1:0]));
        out_q.hit_y         <= 32'(signed'(cmd_i.origin_y[CW-1:0]));
        out_q.hit_found     <= 1'b0;
        out_q.near_vertical <= 1'b1;
      end else begin
        out_q.hit_x         <= 32'(sx_q);
        out_q.hit_y         <= 32'(sy_q);
        out_q.hit_found     <= 1'b0;
        out_q.near_vertical <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[rtl/core/rsnh_mul.sv]
module rsnh_mul #(
  parameter int unsigned COORD_BITS = rsnh_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic [rsnh_pkg::mag_width(COORD_BITS)-1:0]     a_i,
  input  logic [rsnh_pkg::mag_width(COORD_BITS)-1:0]     b_i,
  output logic                                           done_o,
  output logic [2*rsnh_pkg::mag_width(COORD_BITS)-1:0]   prod_o
);
  import rsnh_pkg::*;

  localparam int unsigned MB    = mag_width(COORD_BITS);
  localparam int unsigned STEPS = MB / 4;
  localparam int unsigned CNTW  = $clog2(STEPS);

  logic [2*MB-1:0] p_q;
  logic [MB-1:0]   a_q;
  logic [CNTW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [MB+3:0]   sum;

  // Radix-16 shift and add: one multiplier digit per cycle.
  assign sum = {4'b0, p_q[2*MB-1:MB]} + ((MB+4)'(a_q) * (MB+4)'(p_q[3:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{MB{1'b0}}, b_i};
      a_q <= a_i;
    end else if (run_q) begin
      p_q <= {sum, p_q[MB-1:4]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

[rtl/core/rsnh_div.sv]
module rsnh_div #(
  parameter int unsigned COORD_BITS = rsnh_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic [2*rsnh_pkg::mag_width(COORD_BITS)-1:0]   dividend_i,
  input  logic [rsnh_pkg::mag_width(COORD_BITS)-1:0]     divisor_i,
  output logic                                           done_o,
  output logic [rsnh_pkg::coord_width(COORD_BITS)+1:0]   quot_o
);
  import rsnh_pkg::*;

  localparam int unsigned MB   = mag_width(COORD_BITS);
  localparam int unsigned QB   = coord_width(COORD_BITS) + 1;
  localparam int unsigned CNTW = $clog2(QB);

  logic [MB:0]     rem_q;
  logic [QB-1:0]   sh_q;
  logic [MB-1:0]   d_q;
  logic [CNTW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [MB:0]     trial;
  logic            ge;
  logic            round_up;

  // Restoring division, one quotient bit per cycle. The quotient is known
  // to fit in QB bits, so the high dividend bits seed the remainder.
  assign trial = {rem_q[MB-1:0], sh_q[QB-1]};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(QB - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (MB+1)'(dividend_i >> QB);
      sh_q  <= dividend_i[QB-1:0];
      d_q   <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? (trial - {1'b0, d_q}) : trial;
      sh_q  <= {sh_q[QB-2:0], ge};
    end
  end

  // Halves round away from zero: twice the remainder against the divisor.
  assign round_up = {rem_q, 1'b0} >= {2'b0, d_q};
  assign quot_o   = {1'b0, sh_q} + (QB+1)'(round_up);
  assign done_o   = done_q;

endmodule
